FILE: hw/rtl/bxt_pkg.sv
// Package for the binary trie maximum-XOR lookup block.
// Holds field widths, operation and status codes, and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bxt_pkg;

  // Fixed field widths of the request and response words
  localparam int KEY_W = 62;
  localparam int TAG_W = 10;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_CHECK,
    S_LINK,
    S_FILL,
    S_TAG,
    S_LEAF,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bxt_req_if.sv
// Request channel of the trie lookup block: valid/ready plus one request word.
// Depends on bxt_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bxt_req_if;
  import bxt_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [KEY_W-1:0] key;
  logic [TAG_W-1:0] tag;

  modport source (output valid, operation, key, tag, input ready);
  modport sink   (input valid, operation, key, tag, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bxt_rsp_if.sv
// Response channel of the trie lookup block: valid/ready plus one result word.
// Depends on bxt_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bxt_rsp_if;
  import bxt_pkg::*;

  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] found_tag;
  logic [1:0]       status;

  modport source (output valid, found_tag, status, input ready);
  modport sink   (input valid, found_tag, status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/bxt_node_store.sv
// Node store of the trie: child-pair memory and leaf tag memory.
// One shared read address, registered read data, one write port per memory.
`timescale 1ns / 1ps
`default_nettype none

module bxt_node_store #(
  parameter int DEPTH = 8192,
  parameter int IDX_W = 13,
  parameter int TSW   = 10
) (
  input  wire logic               clk,
  input  wire logic [IDX_W-1:0]   rd_addr,
  output logic      [2*IDX_W-1:0] rd_row,
  output logic      [TSW-1:0]     rd_tag,
  input  wire logic               row_we,
  input  wire logic [IDX_W-1:0]   row_waddr,
  input  wire logic [2*IDX_W-1:0] row_wdata,
  input  wire logic               tag_we,
  input  wire logic [IDX_W-1:0]   tag_waddr,
  input  wire logic [TSW-1:0]     tag_wdata
);

  // Row layout: {one child, zero child}
  logic [2*IDX_W-1:0] child_mem [DEPTH];
  logic [TSW-1:0]     leaf_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (row_we) begin
      child_mem[row_waddr] <= row_wdata;
    end
    rd_row <= child_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      leaf_mem[tag_waddr] <= tag_wdata;
    end
    rd_tag <= leaf_mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/binary_trie_max_xor_lookup_top.sv
// Binary trie with insert and maximum-XOR query, walked one level per cycle.
// Depends on bxt_pkg, bxt_req_if, bxt_rsp_if and bxt_node_store.
//
// Usage: req carries one word per operation: operation (insert or query), key,
//   tag. rsp returns exactly one word per request: found_tag and status
//   (ok, query on empty trie, insert refused because the node pool is full).
//   A word is taken when valid and ready are both high at a rising clk edge.
// Timing: the sequencer walks the node memory one trie level per cycle, so
//   the node memory read port sets the pace. Steps from taking to rsp.valid:
//   Query: walk all KEY_BITS levels, read the leaf tag, load the result.
//   Query on an empty trie: go straight to the result.
//   Insert: walk down to the first missing child, check the pool, write the
//   link, fill the new nodes one by one, write the tag, load the result.
//   A refused insert ends after the pool check; a key already stored skips
//   check, link and fill. One word is in work at a time.
// Reset: synchronous rst empties the trie (root has no children, one node
//   in use) and drops any result word. The node memories need no clearing:
//   a node is written in full when it is allocated.
// Stall: a finished result sits in the output register; the sequencer holds
//   in its result stage until that register is free, then goes back to idle.
`timescale 1ns / 1ps
`default_nettype none

module binary_trie_max_xor_lookup_top #(
  parameter int KEY_BITS  = 62,
  parameter int NODE_POOL = 8192,
  parameter int TAG_BITS  = 10
) (
  input wire logic clk,
  input wire logic rst,
  bxt_req_if.sink  req,
  bxt_rsp_if.source rsp
);
  import bxt_pkg::*;

  localparam int IDX_W  = $clog2(NODE_POOL);
  localparam int CNT_W  = $clog2(NODE_POOL + 1);
  localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int NEED_W = $clog2(KEY_BITS + 1);
  localparam int TSW    = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  // Sequencer state
  state_t state, state_next;

  // Control registers
  logic [CNT_W-1:0]   nodes_used, nodes_used_next;
  logic [2*IDX_W-1:0] root_row, root_row_next;
  logic               out_valid, out_valid_next;

  // Working registers
  logic               op, op_next;
  logic [KEY_BITS-1:0] key_sh, key_sh_next;
  logic [TSW-1:0]     tag_q, tag_q_next;
  logic [LVL_W-1:0]   lvl, lvl_next;
  logic [IDX_W-1:0]   node, node_next;
  logic [IDX_W-1:0]   alloc, alloc_next;
  logic [NEED_W-1:0]  need, need_next;
  logic [TAG_W-1:0]   res_tag, res_tag_next;
  status_t            res_status, res_status_next;
  logic [TAG_W-1:0]   found_tag, found_tag_next;
  status_t            status, status_next;

  // Node store connections
  logic [2*IDX_W-1:0] rd_row;
  logic [TSW-1:0]     rd_tag;
  logic               row_we;
  logic [IDX_W-1:0]   row_waddr;
  logic [2*IDX_W-1:0] row_wdata;
  logic               tag_we;
  logic [IDX_W-1:0]   tag_waddr;

  // Walk datapath
  logic [2*IDX_W-1:0]  cur_row;
  logic [IDX_W-1:0]    zero_c, one_c, sel_c, opp_c, pick_c;
  logic                kbit, kbit_nx;
  logic [KEY_BITS-1:0] key_adv;
  logic [63:0]         key_ext;
  logic                accept, empty_trie, pool_fits, out_load, last_lvl;
  logic [CNT_W:0]      need_sum;

  bxt_node_store #(
    .DEPTH (NODE_POOL),
    .IDX_W (IDX_W),
    .TSW   (TSW)
  ) u_store (
    .clk       (clk),
    .rd_addr   (node_next),
    .rd_row    (rd_row),
    .rd_tag    (rd_tag),
    .row_we    (row_we),
    .row_waddr (row_waddr),
    .row_wdata (row_wdata),
    .tag_we    (tag_we),
    .tag_waddr (tag_waddr),
    .tag_wdata (tag_q)
  );

  // The read data always belongs to the current node; the root lives in flops.
  assign cur_row  = (node == '0) ? root_row : rd_row;
  assign zero_c   = cur_row[IDX_W-1:0];
  assign one_c    = cur_row[2*IDX_W-1:IDX_W];
  assign kbit     = key_sh[KEY_BITS-1];
  assign key_adv  = key_sh << 1;
  assign kbit_nx  = key_adv[KEY_BITS-1];
  assign sel_c    = kbit ? one_c : zero_c;
  assign opp_c    = kbit ? zero_c : one_c;
  assign pick_c   = (opp_c != '0) ? opp_c : sel_c;
  assign last_lvl = (lvl == '0);

  assign accept     = req.valid && req.ready;
  assign empty_trie = (nodes_used <= CNT_W'(1));
  assign need_sum   = {1'b0, nodes_used} + (CNT_W + 1)'(need);
  assign pool_fits  = (need_sum <= (CNT_W + 1)'(NODE_POOL));
  assign out_load   = (state == S_DONE) && (!out_valid || rsp.ready);
  assign key_ext    = 64'(req.key);

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.found_tag = found_tag;
  assign rsp.status    = status;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.operation == OP_QUERY && empty_trie) begin
            state_next = S_DONE;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (op == OP_QUERY) begin
          if (last_lvl) begin
            state_next = S_LEAF;
          end
        end else if (sel_c == '0) begin
          state_next = S_CHECK;
        end else if (last_lvl) begin
          state_next = S_TAG;
        end
      end
      S_CHECK: state_next = pool_fits ? S_LINK : S_DONE;
      S_LINK:  state_next = S_FILL;
      S_FILL: begin
        if (last_lvl) begin
          state_next = S_TAG;
        end
      end
      S_TAG:  state_next = S_DONE;
      S_LEAF: state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_next         = op;
    key_sh_next     = key_sh;
    tag_q_next      = tag_q;
    lvl_next        = lvl;
    node_next       = node;
    alloc_next      = alloc;
    need_next       = need;
    nodes_used_next = nodes_used;
    root_row_next   = root_row;
    res_tag_next    = res_tag;
    res_status_next = res_status;
    row_we          = 1'b0;
    row_waddr       = alloc;
    row_wdata       = '0;
    tag_we          = 1'b0;
    tag_waddr       = node;

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_next         = req.operation;
          key_sh_next     = key_ext[KEY_BITS-1:0];
          tag_q_next      = req.tag[TSW-1:0];
          lvl_next        = LVL_W'(KEY_BITS - 1);
          node_next       = '0;
          res_tag_next    = '0;
          res_status_next = (req.operation == OP_QUERY && empty_trie) ? ST_EMPTY : ST_OK;
        end
      end
      S_WALK: begin
        if (op == OP_QUERY) begin
          // Prefer the child opposite to the key bit
          node_next = pick_c;
          if (!last_lvl) begin
            lvl_next    = lvl - LVL_W'(1);
            key_sh_next = key_adv;
          end
        end else if (sel_c == '0) begin
          // Levels lvl down to 0 each need a fresh node
          need_next = NEED_W'(lvl) + NEED_W'(1);
        end else begin
          node_next = sel_c;
          need_next = '0;
          if (!last_lvl) begin
            lvl_next    = lvl - LVL_W'(1);
            key_sh_next = key_adv;
          end
        end
      end
      S_CHECK: begin
        if (!pool_fits) begin
          res_status_next = ST_FULL;
        end
      end
      S_LINK: begin
        // Hang the first new node under the last existing one
        row_wdata = kbit ? {nodes_used[IDX_W-1:0], zero_c} : {one_c, nodes_used[IDX_W-1:0]};
        if (node == '0) begin
          root_row_next = row_wdata;
        end else begin
          row_we    = 1'b1;
          row_waddr = node;
        end
        alloc_next      = nodes_used[IDX_W-1:0];
        nodes_used_next = nodes_used + CNT_W'(need);
      end
      S_FILL: begin
        // Write the whole row of the new node: next new node or nothing
        row_we    = 1'b1;
        row_waddr = alloc;
        if (last_lvl) begin
          row_wdata = '0;
          node_next = alloc;
        end else begin
          row_wdata   = kbit_nx ? {alloc + IDX_W'(1), {IDX_W{1'b0}}}
                                : {{IDX_W{1'b0}}, alloc + IDX_W'(1)};
          alloc_next  = alloc + IDX_W'(1);
          lvl_next    = lvl - LVL_W'(1);
          key_sh_next = key_adv;
        end
      end
      S_TAG: begin
        tag_we    = 1'b1;
        tag_waddr = node;
      end
      S_LEAF: begin
        res_tag_next = TAG_W'(rd_tag);
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_next = out_valid && !rsp.ready;
    found_tag_next = found_tag;
    status_next    = status;
    if (out_load) begin
      out_valid_next = 1'b1;
      found_tag_next = res_tag;
      status_next    = res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nodes_used <= CNT_W'(1);
      root_row   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      nodes_used <= nodes_used_next;
      root_row   <= root_row_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    key_sh     <= key_sh_next;
    tag_q      <= tag_q_next;
    lvl        <= lvl_next;
    node       <= node_next;
    alloc      <= alloc_next;
    need       <= need_next;
    res_tag    <= res_tag_next;
    res_status <= res_status_next;
    found_tag  <= found_tag_next;
    status     <= status_next;
  end

  // The pool never overflows
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= CNT_W'(NODE_POOL))
    else $error("node count beyond pool size");

  // Nodes are only ever added
  a_pool_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> nodes_used >= $past(nodes_used))
    else $error("node count went down");

  // A taken request always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("request taken but sequencer idle");

  // Any non-ok result carries a zero tag
  a_err_tag: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> rsp.found_tag == '0)
    else $error("error result with nonzero tag");

  // The level counter stays inside the key
  a_lvl_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK || state == S_FILL) |-> lvl <= LVL_W'(KEY_BITS - 1))
    else $error("level counter out of range");

endmodule

`default_nettype wire

FILE: dv/bxt_trie_checker.sv
// Scoreboard for the binary trie maximum-XOR lookup block.
// Watches the request and response channels and keeps its own copy of the trie.
// Depends on bxt_pkg, bxt_req_if and bxt_rsp_if.
`timescale 1ns / 1ps

module bxt_trie_checker #(
  parameter int KEY_BITS  = 62,
  parameter int NODE_POOL = 8192
) (
  input  wire logic clk,
  input  wire logic rst,
  bxt_req_if        req,
  bxt_rsp_if        rsp,
  output int        mismatches,
  output int        free_nodes,
  output int        outstanding
);
  import bxt_pkg::*;

  typedef struct {
    logic [TAG_W-1:0] found_tag;
    status_t          status;
  } trie_result_t;

  bit [12:0]      zero_link [NODE_POOL];
  bit [12:0]      one_link  [NODE_POOL];
  bit [TAG_W-1:0] leaf_word [NODE_POOL];
  int             nodes_taken;
  trie_result_t   pending_results [$];

  initial begin
    mismatches  = 0;
    free_nodes  = NODE_POOL - 1;
    outstanding = 0;
    nodes_taken = 1;
  end

  function automatic int link_of(int node, bit b);
    return b ? int'(one_link[node]) : int'(zero_link[node]);
  endfunction

  // Count the missing nodes first; refuse the insert if the pool cannot hold them.
  function automatic status_t trie_insert(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
    int node;
    int need;
    int c;
    int i;
    bit gap;
    node = 0;
    need = 0;
    gap  = 1'b0;
    for (i = KEY_BITS - 1; i >= 0; i--) begin
      if (!gap) begin
        c = link_of(node, key[i]);
        if (c == 0) gap = 1'b1;
        else node = c;
      end
      if (gap) need++;
    end
    if (nodes_taken + need > NODE_POOL) return ST_FULL;

    node = 0;
    for (i = KEY_BITS - 1; i >= 0; i--) begin
      c = link_of(node, key[i]);
      if (c == 0) begin
        c = nodes_taken;
        nodes_taken++;
        zero_link[c] = '0;
        one_link[c]  = '0;
        leaf_word[c] = '0;
        if (key[i]) one_link[node] = 13'(c);
        else zero_link[node] = 13'(c);
      end
      node = c;
    end
    leaf_word[node] = tag;
    return ST_OK;
  endfunction

  // Prefer the child opposite to each key bit to maximize the XOR.
  function automatic trie_result_t trie_query(logic [KEY_W-1:0] key);
    trie_result_t r;
    int node;
    int c;
    int i;
    r.found_tag = '0;
    r.status    = ST_OK;
    if (nodes_taken <= 1) begin
      r.status = ST_EMPTY;
      return r;
    end
    node = 0;
    for (i = KEY_BITS - 1; i >= 0; i--) begin
      c = link_of(node, !key[i]);
      if (c == 0) c = link_of(node, key[i]);
      node = c;
    end
    r.found_tag = leaf_word[node];
    return r;
  endfunction

  always @(posedge clk) begin
    trie_result_t exp_word;
    if (rst) begin
      for (int n = 0; n < NODE_POOL; n++) begin
        zero_link[n] = '0;
        one_link[n]  = '0;
        leaf_word[n] = '0;
      end
      nodes_taken = 1;
      pending_results.delete();
    end else begin
      if (req.valid && req.ready) begin
        if (req.operation == OP_INSERT) begin
          exp_word.found_tag = '0;
          exp_word.status    = trie_insert(req.key, req.tag);
        end else begin
          exp_word = trie_query(req.key);
        end
        pending_results.insert(pending_results.size(), exp_word);
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word: found_tag=%0d status=%0d", rsp.found_tag, rsp.status);
          mismatches++;
        end else begin
          exp_word = pending_results.pop_front();
          if (rsp.found_tag !== exp_word.found_tag) begin
            $error("found_tag: expected %0d, got %0d", exp_word.found_tag, rsp.found_tag);
            mismatches++;
          end
          if (rsp.status !== exp_word.status) begin
            $error("status: expected %0d, got %0d", exp_word.status, rsp.status);
            mismatches++;
          end
        end
      end
    end
    free_nodes  <= NODE_POOL - nodes_taken;
    outstanding <= pending_results.size();
  end

endmodule

FILE: dv/binary_trie_max_xor_lookup_top_tb.sv
// Testbench top for binary_trie_max_xor_lookup_top: clock, reset, stimulus and verdict.
// Depends on bxt_pkg, bxt_req_if, bxt_rsp_if, bxt_trie_checker and the block itself.
`timescale 1ns / 1ps

module binary_trie_max_xor_lookup_top_tb;
  import bxt_pkg::*;

  localparam int KEY_BITS     = 62;
  localparam int NODE_POOL    = 8192;
  localparam int PHASE_WORDS  = 333;
  // Slowest word is an insert of a whole new branch, plus long random stalls on either side.
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches;
  int free_nodes;
  int outstanding;

  // Every key offered for insert, reused to build overwrites and near misses.
  logic [KEY_W-1:0] inserted_keys [$];

  bxt_req_if req ();
  bxt_rsp_if rsp ();

  binary_trie_max_xor_lookup_top #(
    .KEY_BITS (KEY_BITS),
    .NODE_POOL(NODE_POOL),
    .TAG_BITS (TAG_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  bxt_trie_checker #(
    .KEY_BITS (KEY_BITS),
    .NODE_POOL(NODE_POOL)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .mismatches (mismatches),
    .free_nodes (free_nodes),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold all inputs at known values from time zero.
  initial begin
    req.valid     = 1'b0;
    req.operation = OP_INSERT;
    req.key       = '0;
    req.tag       = '0;
    rsp.ready     = 1'b0;
  end

  // Receiver: drop ready at random in the share that the current phase asks.
  always @(negedge clk) begin
    rsp.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall = 0;
      else stall++;
    end
    $display("** binary_trie_max_xor_lookup_top: FAILED **");
    $finish;
  end

  function automatic logic [KEY_W-1:0] rand_key();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[KEY_W-1:0];
  endfunction

  // Keep the bits above pos, flip bit pos, randomize everything below it.
  // The new branch needs at most pos+1 nodes.
  function automatic logic [KEY_W-1:0] branch_off(logic [KEY_W-1:0] base, int pos);
    logic [KEY_W-1:0] below;
    logic [KEY_W-1:0] flipped;
    below   = (KEY_W'(1) << pos) - KEY_W'(1);
    flipped = base ^ (KEY_W'(1) << pos);
    return (flipped & ~below) | (rand_key() & below);
  endfunction

  function automatic logic [KEY_W-1:0] some_inserted_key();
    if (inserted_keys.size() == 0) return rand_key();
    return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
  endfunction

  // Drive one request word at a falling edge and hold it until it is taken.
  task automatic send_word(logic op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.key       <= key;
    req.tag       <= tag;
    if (op == OP_INSERT) inserted_keys.insert(inserted_keys.size(), key);
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // One random word. Inserts mix fresh keys (which eat the node pool fast),
  // overwrites, and short branches off known keys; once the pool runs low,
  // aim some inserts at exactly the nodes left.
  task automatic send_random_word();
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    int pick;
    tag  = TAG_W'($urandom);
    pick = $urandom_range(99);
    if ($urandom_range(1) == 0) begin
      if (free_nodes > 0 && free_nodes <= KEY_BITS && pick < 40)
        key = branch_off(some_inserted_key(), free_nodes - 1);
      else if (pick < 15)
        key = some_inserted_key();
      else if (pick < 45)
        key = rand_key();
      else
        key = branch_off(some_inserted_key(), $urandom_range(20));
      send_word(OP_INSERT, key, tag);
    end else begin
      // Queries: half fully random, half close to a stored key.
      if (pick < 50) key = rand_key();
      else key = some_inserted_key() ^ (rand_key() & rand_key() & rand_key());
      send_word(OP_QUERY, key, tag);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase one: sender idles now and then, receiver stalls most cycles.
    send_idle_pct = 25;
    recv_idle_pct = 81;

    // Queries on the empty trie, tag field set to check that it is ignored.
    send_word(OP_QUERY, '0, '0);
    send_word(OP_QUERY, '1, '1);
    // Extreme keys and tags; while a single key is stored, it answers every query.
    send_word(OP_INSERT, '0, '0);
    send_word(OP_QUERY, '0, '0);
    send_word(OP_INSERT, '1, '1);
    send_word(OP_QUERY, '0, 10'd7);
    send_word(OP_QUERY, '1, '0);
    // Overwrite the tag of a key that is already stored.
    send_word(OP_INSERT, '0, 10'd5);
    send_word(OP_QUERY, '1, '0);
    // Alternating patterns: each is the other's complement.
    send_word(OP_INSERT, {31{2'b10}}, 10'h155);
    send_word(OP_INSERT, {31{2'b01}}, 10'h2aa);
    send_word(OP_QUERY, {31{2'b10}}, '0);
    send_word(OP_QUERY, {31{2'b01}}, '0);
    // Single-bit keys at the top and bottom of the walk.
    send_word(OP_INSERT, KEY_W'(1) << (KEY_W - 1), 10'd1);
    send_word(OP_INSERT, KEY_W'(1), 10'h200);
    send_word(OP_QUERY, KEY_W'(1) << (KEY_W - 1), '1);
    send_word(OP_QUERY, KEY_W'(1), '0);
    send_word(OP_INSERT, '1, 10'h3ff);
    send_word(OP_QUERY, KEY_W'(0), '0);

    repeat (PHASE_WORDS) send_random_word();

    // Phase two: swap the idle shares.
    send_idle_pct = 81;
    recv_idle_pct = 25;
    repeat (PHASE_WORDS) send_random_word();

    // Phase three: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (PHASE_WORDS + 1) send_random_word();

    req.valid <= 1'b0;
    // Wait for the last result word, then let any late extra word show up.
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("** binary_trie_max_xor_lookup_top: PASSED **");
    else
      $display("** binary_trie_max_xor_lookup_top: FAILED **");
    $finish;
  end

endmodule

FILE: binary_trie_max_xor_lookup_top.f
hw/rtl/bxt_pkg.sv
hw/rtl/bxt_req_if.sv
hw/rtl/bxt_rsp_if.sv
hw/rtl/bxt_node_store.sv
hw/rtl/binary_trie_max_xor_lookup_top.sv
dv/bxt_trie_checker.sv
dv/binary_trie_max_xor_lookup_top_tb.sv
